### src/gzd_pkg.sv
package gzd_pkg;

    // Sizes
    localparam int HISTORY_DEPTH = 8;
    localparam int MAX_DIGITS    = 16;
    localparam int POS_W         = 16;
    localparam int HIST_AW       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = POS_W + HIST_AW;
    localparam int DFILL_W       = 5;
    localparam int PACKED_W      = 64;

    // Configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 15;

    // Stream widths
    localparam int S_TDATA_W = 2 * POS_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;

    // Reset values of the configuration registers
    localparam logic [14:0] THRESHOLD_RESET = 15'd3932;
    localparam logic [7:0]  DEBOUNCE_RESET  = 8'd10;
    localparam logic [7:0]  RELOAD_RESET    = 8'd74;
    localparam logic [7:0]  GAIN_RESET      = 8'd37;
    localparam logic [7:0]  GOAL_RESET      = 8'd125;
    localparam logic [3:0]  HLEN_RESET      = 4'd5;

    // Choice codes
    localparam logic [3:0] CHOICE_DELETE   = 4'd10;
    localparam logic [3:0] CHOICE_CALL     = 4'd11;
    localparam logic [3:0] CHOICE_YES      = 4'd1;
    localparam logic [3:0] INPUT_CHOICES   = 4'd12;
    localparam logic [3:0] CONFIRM_CHOICES = 4'd2;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_NEXT   = 2'd2,
        OP_PREV   = 2'd3
    } op_t;

    typedef enum logic [CFG_IW-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_DEBOUNCE  = 3'd1,
        CFG_RELOAD    = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_GOAL      = 3'd4,
        CFG_HLEN      = 3'd5
    } cfg_idx_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } gzd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic               need_sum;
        logic [HIST_CW-1:0] win_n;
        logic               out_free;
    } gzd_status_t;

endpackage

### src/gzd_ram.sv
module gzd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/gzd_ctrl.sv
module gzd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gzd_pkg::gzd_status_t status,
    output gzd_pkg::gzd_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SUM,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [gzd_pkg::HIST_CW-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cnt_next   = '0;
                state_next = status.need_sum ? S_SUM : S_FINISH;
            end
            S_SUM: begin
                cnt_next = gzd_pkg::HIST_CW'(cnt_reg + 1'b1);
                if (cnt_next == status.win_n) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.load   = s_tvalid && (state_reg == S_IDLE);
    assign cmd.rd_en  = (state_reg == S_SUM);
    assign cmd.finish = (state_reg == S_FINISH) && status.out_free;

endmodule

### src/gzd_datapath.sv
module gzd_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gzd_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [gzd_pkg::CFG_DW-1:0]      cfg_wr_data,
    input  logic [gzd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [gzd_pkg::S_TUSER_W-1:0]   s_tuser,
    input  gzd_pkg::gzd_cmd_t               cmd,
    output gzd_pkg::gzd_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gzd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int DW      = gzd_pkg::MAX_DIGITS * 4;
    localparam int PROD_W  = 17 + gzd_pkg::HIST_CW;
    localparam int AW      = gzd_pkg::HIST_AW;
    localparam int CW      = gzd_pkg::HIST_CW;
    localparam int FW      = gzd_pkg::DFILL_W;
    localparam int Depth   = gzd_pkg::HISTORY_DEPTH;

    localparam logic [1:0] MOVE_CENTER = 2'd0;
    localparam logic [1:0] MOVE_LEFT   = 2'd1;
    localparam logic [1:0] MOVE_RIGHT  = 2'd2;

    localparam logic [1:0] MODE_WAIT    = 2'd0;
    localparam logic [1:0] MODE_INPUT   = 2'd1;
    localparam logic [1:0] MODE_CONFIRM = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_PUSH    = 3'd1;
    localparam logic [2:0] EV_DELETE  = 3'd2;
    localparam logic [2:0] EV_CONFIRM = 3'd3;
    localparam logic [2:0] EV_ACCEPT  = 3'd4;
    localparam logic [2:0] EV_DECLINE = 3'd5;

    localparam logic [16:0] CENTER_POS = 17'd32768;

    // Step the choice one place forward or back, wrapping in the mode's range.
    function automatic logic [3:0] step_choice(input logic [1:0] m, input logic [3:0] c,
                                               input logic fwd);
        logic [3:0] limit;
        logic [3:0] cur;
        limit = (m == MODE_INPUT) ? gzd_pkg::INPUT_CHOICES : gzd_pkg::CONFIRM_CHOICES;
        cur   = (c >= limit) ? 4'd0 : c;
        if (fwd) begin
            step_choice = (cur == limit - 4'd1) ? 4'd0 : cur + 4'd1;
        end else begin
            step_choice = (cur == 4'd0) ? limit - 4'd1 : cur - 4'd1;
        end
    endfunction

    // Configuration
    logic [14:0] thr_reg;
    logic [7:0]  deb_ticks_reg;
    logic [7:0]  reload_reg;
    logic [7:0]  gain_reg;
    logic [7:0]  goal_reg;
    logic [3:0]  hlen_reg;

    // Block state
    logic [1:0]    mode_reg, mode_next;
    logic [3:0]    choice_reg, choice_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] head_reg, head_next;
    logic [7:0]    deb_reg, deb_next;
    logic [7:0]    cd_reg, cd_next;
    logic [7:0]    pts_reg, pts_next;
    logic [1:0]    last_reg, last_next;
    logic [FW-1:0] dfill_reg, dfill_next;
    logic [DW-1:0] digits_reg, digits_next;

    // Item and window sum
    gzd_pkg::op_t                op_reg;
    logic [gzd_pkg::POS_W-1:0]   lx_reg, rx_reg;
    logic [gzd_pkg::SUM_W-1:0]   sum_reg;
    logic [AW-1:0]               rd_ptr_reg;
    logic [AW-1:0]               rd_prev;
    logic                        acc_pend_reg;
    logic [gzd_pkg::POS_W-1:0]   rd_data;
    logic [gzd_pkg::POS_W-1:0]   sample_val;
    logic                        ram_we;

    // Output register
    logic                           m_tvalid_reg;
    logic [gzd_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                           out_free;

    // Classification
    logic [CW-1:0]     wl;
    logic [CW-1:0]     win_n;
    logic [16:0]       lo_bound, hi_bound;
    logic [PROD_W-1:0] prod_lo, prod_hi, sum_ext;
    logic [1:0]        class_mv;

    logic [1:0]                   mv;
    logic [2:0]                   ev;
    logic [8:0]                   pts_sum;
    logic [gzd_pkg::PACKED_W-1:0] packed_vis;

    always_comb begin
        if (hlen_reg == 4'd0) begin
            wl = CW'(1);
        end else if (int'(hlen_reg) > Depth) begin
            wl = CW'(Depth);
        end else begin
            wl = CW'(hlen_reg);
        end
        win_n = (fill_reg < wl) ? fill_reg : wl;
    end

    // floor(sum/n) < lo  <=>  sum < n*lo ; floor(sum/n) > C+T  <=>  sum >= n*(C+T+1)
    always_comb begin
        lo_bound = CENTER_POS - {2'b00, thr_reg};
        hi_bound = CENTER_POS + {2'b00, thr_reg} + 17'd1;
        prod_lo  = PROD_W'(win_n) * PROD_W'(lo_bound);
        prod_hi  = PROD_W'(win_n) * PROD_W'(hi_bound);
        sum_ext  = PROD_W'(sum_reg);
        if (win_n == '0) begin
            class_mv = MOVE_CENTER;
        end else if (sum_ext < prod_lo) begin
            class_mv = MOVE_LEFT;
        end else if (sum_ext >= prod_hi) begin
            class_mv = MOVE_RIGHT;
        end else begin
            class_mv = MOVE_CENTER;
        end
    end

    assign rd_prev    = (rd_ptr_reg == '0) ? AW'(Depth - 1) : AW'(rd_ptr_reg - 1'b1);
    assign sample_val = gzd_pkg::POS_W'(({1'b0, lx_reg} + {1'b0, rx_reg}) >> 1);

    // Next state of one item; for a tick: countdown and commit, then gaze step, then point leak.
    always_comb begin
        mode_next   = mode_reg;
        choice_next = choice_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        deb_next    = deb_reg;
        cd_next     = cd_reg;
        pts_next    = pts_reg;
        last_next   = last_reg;
        dfill_next  = dfill_reg;
        digits_next = digits_reg;
        mv          = MOVE_CENTER;
        ev          = EV_NONE;
        pts_sum     = '0;
        ram_we      = 1'b0;
        case (op_reg)
            gzd_pkg::OP_SAMPLE: begin
                ram_we    = 1'b1;
                head_next = (head_reg == AW'(Depth - 1)) ? '0 : AW'(head_reg + 1'b1);
                fill_next = (fill_reg < wl) ? CW'(fill_reg + 1'b1) : wl;
            end
            gzd_pkg::OP_TICK: begin
                if (cd_reg != 8'd0) begin
                    cd_next = cd_reg - 8'd1;
                end else begin
                    cd_next = reload_reg;
                    case (mode_reg)
                        MODE_INPUT: begin
                            if (choice_reg == gzd_pkg::CHOICE_DELETE) begin
                                if (dfill_reg != '0) begin
                                    dfill_next = dfill_reg - FW'(1);
                                    ev         = EV_DELETE;
                                end
                            end else if (choice_reg == gzd_pkg::CHOICE_CALL) begin
                                mode_next   = MODE_CONFIRM;
                                choice_next = 4'd0;
                                ev          = EV_CONFIRM;
                            end else if (choice_reg <= 4'd9 &&
                                         int'(dfill_reg) < gzd_pkg::MAX_DIGITS) begin
                                for (int k = 0; k < gzd_pkg::MAX_DIGITS; k++) begin
                                    if (FW'(k) == dfill_reg) begin
                                        digits_next[4*k +: 4] = choice_reg;
                                    end
                                end
                                dfill_next = dfill_reg + FW'(1);
                                ev         = EV_PUSH;
                            end
                        end
                        MODE_CONFIRM: begin
                            ev          = (choice_reg == gzd_pkg::CHOICE_YES) ? EV_ACCEPT
                                                                              : EV_DECLINE;
                            mode_next   = MODE_WAIT;
                            choice_next = 4'd0;
                            pts_next    = 8'd0;
                            last_next   = MOVE_CENTER;
                        end
                        default: begin
                            ev = EV_NONE;
                        end
                    endcase
                end

                if (deb_reg != 8'd0) begin
                    deb_next = deb_reg - 8'd1;
                end else begin
                    mv = class_mv;
                    if (mode_next == MODE_WAIT) begin
                        if (mv != MOVE_CENTER) begin
                            if (last_next != mv) begin
                                pts_sum  = {1'b0, pts_next} + {1'b0, gain_reg};
                                pts_next = pts_sum[8] ? 8'd255 : pts_sum[7:0];
                            end
                            if (pts_next >= goal_reg) begin
                                mode_next   = MODE_INPUT;
                                choice_next = 4'd0;
                                pts_next    = 8'd0;
                                last_next   = MOVE_CENTER;
                            end else begin
                                last_next = mv;
                            end
                        end
                    end else if (mv != MOVE_CENTER) begin
                        choice_next = step_choice(mode_next, choice_next, mv == MOVE_RIGHT);
                        cd_next     = reload_reg;
                    end
                    if (mv != MOVE_CENTER) begin
                        deb_next = deb_ticks_reg;
                    end
                end

                if (mode_next == MODE_WAIT && pts_next != 8'd0) begin
                    pts_next = pts_next - 8'd1;
                end
            end
            gzd_pkg::OP_NEXT, gzd_pkg::OP_PREV: begin
                if (mode_reg != MODE_WAIT) begin
                    choice_next = step_choice(mode_reg, choice_reg,
                                              op_reg == gzd_pkg::OP_NEXT);
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        packed_vis = '0;
        for (int k = 0; k < gzd_pkg::MAX_DIGITS; k++) begin
            if (FW'(k) < dfill_next) begin
                packed_vis[4*k +: 4] = digits_next[4*k +: 4];
            end
        end
    end

    gzd_ram #(
        .WIDTH (gzd_pkg::POS_W),
        .DEPTH (Depth)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (cmd.finish && ram_we),
        .wr_addr (head_reg),
        .wr_data (sample_val),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_prev),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= gzd_pkg::THRESHOLD_RESET;
            deb_ticks_reg <= gzd_pkg::DEBOUNCE_RESET;
            reload_reg    <= gzd_pkg::RELOAD_RESET;
            gain_reg      <= gzd_pkg::GAIN_RESET;
            goal_reg      <= gzd_pkg::GOAL_RESET;
            hlen_reg      <= gzd_pkg::HLEN_RESET;
            mode_reg      <= MODE_WAIT;
            choice_reg    <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            deb_reg       <= '0;
            cd_reg        <= gzd_pkg::RELOAD_RESET;
            pts_reg       <= '0;
            last_reg      <= MOVE_CENTER;
            dfill_reg     <= '0;
            acc_pend_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (gzd_pkg::cfg_idx_t'(cfg_index))
                    gzd_pkg::CFG_THRESHOLD: thr_reg       <= cfg_wr_data[14:0];
                    gzd_pkg::CFG_DEBOUNCE:  deb_ticks_reg <= cfg_wr_data[7:0];
                    gzd_pkg::CFG_RELOAD:    reload_reg    <= cfg_wr_data[7:0];
                    gzd_pkg::CFG_GAIN:      gain_reg      <= cfg_wr_data[7:0];
                    gzd_pkg::CFG_GOAL:      goal_reg      <= cfg_wr_data[7:0];
                    gzd_pkg::CFG_HLEN:      hlen_reg      <= cfg_wr_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.finish) begin
                mode_reg   <= mode_next;
                choice_reg <= choice_next;
                fill_reg   <= fill_next;
                head_reg   <= head_next;
                deb_reg    <= deb_next;
                cd_reg     <= cd_next;
                pts_reg    <= pts_next;
                last_reg   <= last_next;
                dfill_reg  <= dfill_next;
            end
            acc_pend_reg <= cmd.rd_en;
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= gzd_pkg::op_t'(s_tuser);
            lx_reg     <= s_tdata[gzd_pkg::POS_W-1:0];
            rx_reg     <= s_tdata[2*gzd_pkg::POS_W-1:gzd_pkg::POS_W];
            sum_reg    <= '0;
            rd_ptr_reg <= head_reg;
        end else begin
            if (cmd.rd_en) begin
                rd_ptr_reg <= rd_prev;
            end
            if (acc_pend_reg) begin
                sum_reg <= sum_reg + gzd_pkg::SUM_W'(rd_data);
            end
        end
        if (cmd.finish) begin
            digits_reg  <= digits_next;
            m_tdata_reg <= {pts_next, cd_next, packed_vis, dfill_next, ev, mv,
                            choice_next, mode_next};
        end
    end

    assign out_free        = !m_tvalid_reg || m_tready;
    assign status.need_sum = (op_reg == gzd_pkg::OP_TICK) && (deb_reg == 8'd0) &&
                             (win_n != '0);
    assign status.win_n    = win_n;
    assign status.out_free = out_free;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

### src/gaze_gesture_dialer_controller.sv
// Channel   Direction  Ports                          Content
// s_        in         s_tvalid s_tready s_tdata       pupil sample, tick or key request
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata       dialer status after each request
// cfg_      in         cfg_wr_en cfg_index cfg_wr_data register writes, no read-back
//
// A sample, a key, or a tick with debounce running or an empty window goes
// through accept, dispatch and apply, and the next request is taken only after
// apply, which loads the result into the output register. A tick that classifies
// a filled window first sums n (1..8) entries, one per cycle from the history RAM.
// Reset (aresetn low, synchronous) loads the register defaults and empties
// the window and the digit buffer. A stalled result holds in the output
// register; the next request is taken meanwhile and waits at its final step.
module gaze_gesture_dialer_controller (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Configuration writes
    input  logic                             cfg_wr_en,
    input  logic [gzd_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [gzd_pkg::CFG_DW-1:0]       cfg_wr_data,

    // Requests
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gzd_pkg::S_TDATA_W-1:0]    s_tdata,   // left_x[15:0], right_x[31:16]
    input  logic [gzd_pkg::S_TUSER_W-1:0]    s_tuser,   // operation[1:0]

    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mode[1:0], choice_index[5:2], movement[7:6], commit_event[10:8],
    // digit_count[15:11], digits_packed[79:16], countdown_value[87:80],
    // unlock_points[95:88]
    output logic [gzd_pkg::M_TDATA_W-1:0]    m_tdata
);

    gzd_pkg::gzd_cmd_t    cmd;
    gzd_pkg::gzd_status_t status;

    // Sequence each request: accept, dispatch, sum the window when needed, apply.
    gzd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold history, choice state, digits and the result register.
    gzd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
